// ----- rtl/lws_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lws_pkg
// Shared types, codes and keyword constants of the lexer with symbol table.
// ----------------------------------------------------------------------------
package lws_pkg;

	localparam int MaxNameDef    = 16;
	localparam int TableDepthDef = 64;

	localparam logic [3:0] KIND_FUNC = 4'd6;
	localparam logic [3:0] KIND_VAR  = 4'd7;
	localparam logic [3:0] KIND_NUM  = 4'd8;
	localparam logic [3:0] KIND_OP   = 4'd9;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_FULL = 2'd1;
	localparam logic [1:0] ERR_LONG = 2'd2;

	localparam logic [7:0] CH_LPAREN = 8'd40;
	localparam logic [7:0] CH_MINUS  = 8'd45;

	localparam int KwCount  = 6;
	localparam int KwMaxLen = 14;

	localparam logic [KwMaxLen*8-1:0] KW_TEXT [KwCount] = '{
		"itakenooffence", "iamoffended", "oneminute",
		"leavemealone", "givememoney", "gototheshop"
	};
	localparam int KW_LEN [KwCount] = '{14, 11, 9, 12, 11, 11};

	function automatic logic [7:0] kw_char(input int k, input int i);
		logic [KwMaxLen*8-1:0] t;
		t = KW_TEXT[k] << (8 * (KwMaxLen - KW_LEN[k]));
		return t[8*(KwMaxLen-1-i) +: 8];
	endfunction

	typedef struct packed {
		logic start;
		logic fn;
	} lws_req_t;

	typedef struct packed {
		logic done;
		logic full;
	} lws_resp_t;

endpackage
`default_nettype wire

// ----- rtl/lws_symtab.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lws_symtab
// Symbol table: one row per entry in a synchronous memory, linear search,
// insert on miss while the table has room.
// ----------------------------------------------------------------------------
module lws_symtab
	import lws_pkg::*;
#(
	parameter int MAX_NAME    = MaxNameDef,
	parameter int TABLE_DEPTH = TableDepthDef,
	localparam int LW = $clog2(MAX_NAME + 2),
	localparam int IW = $clog2(TABLE_DEPTH)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire lws_req_t              req,
	input  wire logic [LW-1:0]         len,
	input  wire logic [MAX_NAME*8-1:0] chars,
	output lws_resp_t                  rsp,
	output logic [IW-1:0]              index
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int RW = 1 + LW + MAX_NAME * 8;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_CMP  = 4'b0100,
		ST_MISS = 4'b1000
	} st_t;

	st_t            st_q;
	logic [RW-1:0]  mem [TABLE_DEPTH];
	logic [RW-1:0]  rd_data_q;
	logic [RW-1:0]  key_q;
	logic [IW-1:0]  idx_q;
	logic [CW-1:0]  cnt_q;
	lws_resp_t      rsp_q;
	logic [IW-1:0]  index_q;
	logic           wr_en;
	logic           last_entry;

	assign wr_en      = (st_q == ST_MISS) && (cnt_q != CW'(TABLE_DEPTH));
	assign last_entry = (CW'(idx_q) + CW'(1)) == cnt_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cnt_q[IW-1:0]] <= key_q;
		end
		rd_data_q <= mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (req.start && st_q == ST_IDLE) begin
			key_q <= {req.fn, len, chars};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			idx_q   <= '0;
			cnt_q   <= '0;
			rsp_q   <= '0;
			index_q <= '0;
		end else begin
			rsp_q <= '0;
			unique case (st_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (req.start) begin
						st_q <= (cnt_q == '0) ? ST_MISS : ST_READ;
					end
				end
				ST_READ: begin
					st_q <= ST_CMP;
				end
				ST_CMP: begin
					if (rd_data_q == key_q) begin
						rsp_q.done <= 1'b1;
						index_q    <= idx_q;
						st_q       <= ST_IDLE;
					end else if (last_entry) begin
						st_q <= ST_MISS;
					end else begin
						idx_q <= idx_q + IW'(1);
						st_q  <= ST_READ;
					end
				end
				ST_MISS: begin
					rsp_q.done <= 1'b1;
					if (wr_en) begin
						index_q <= cnt_q[IW-1:0];
						cnt_q   <= cnt_q + CW'(1);
					end else begin
						rsp_q.full <= 1'b1;
					end
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp   = rsp_q;
	assign index = index_q;

endmodule
`default_nettype wire

// ----- rtl/lexer_with_symbol_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lexer_with_symbol_table
// Character scanner producing keyword, name, number and operator tokens.
// ----------------------------------------------------------------------------
// One transaction at a time: a character is decoded in the cycle after accept.
// Words that end then pass the keyword check (T_WORD); names that are not
// keywords or too long search the symbol table one entry after another.
// Results leave one per cycle while out_stall is low; input resumes after the last.
// Reset clears scanner state and empties the table (entry count to zero).
// ----------------------------------------------------------------------------
module lexer_with_symbol_table
	import lws_pkg::*;
#(
	parameter int MAX_NAME    = MaxNameDef,
	parameter int TABLE_DEPTH = TableDepthDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  text_char,
	input  wire logic        end_of_text,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [3:0]       token_kind,
	output logic signed [31:0] token_value,
	output logic [1:0]       error_code,
	output logic             last_of_run
);

	localparam int LW  = $clog2(MAX_NAME + 2);
	localparam int IW  = $clog2(TABLE_DEPTH);
	localparam int WIW = $clog2(MAX_NAME);

	typedef enum logic [4:0] {
		T_IDLE   = 5'b00001,
		T_DECODE = 5'b00010,
		T_WORD   = 5'b00100,
		T_SEARCH = 5'b01000,
		T_DRAIN  = 5'b10000
	} tst_t;

	typedef enum logic [3:0] {
		MODE_IDLE  = 4'b0001,
		MODE_WORD  = 4'b0010,
		MODE_NUM   = 4'b0100,
		MODE_MINUS = 4'b1000
	} mode_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'd48 && c <= 8'd57;
	endfunction

	function automatic logic is_dropped(input logic [7:0] c);
		return c == 8'd0 || c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic [31:0] add_digit(input logic [31:0] a, input logic [7:0] c);
		logic [35:0] v;
		v = 36'({a, 3'b000}) + 36'({a, 1'b0}) + 36'(c - 8'd48);
		return (v > 36'h080000000) ? 32'h80000000 : v[31:0];
	endfunction

	function automatic logic [31:0] fin_num(input logic [31:0] a, input logic neg);
		if (neg) begin
			return 32'd0 - a;
		end
		return (a > 32'h7FFFFFFF) ? 32'h7FFFFFFF : a;
	endfunction

	tst_t         st_q;
	mode_t        mode_q;
	logic [7:0]   c_q;
	logic         end_q;
	logic [7:0]   wbuf_q [MAX_NAME];
	logic [LW-1:0] wlen_q;
	logic         neg_q;
	logic [7:0]   prev_q;
	logic [31:0]  acc_q;
	logic [3:0]   res_kind_q [2];
	logic [31:0]  res_val_q [2];
	logic [1:0]   res_err_q [2];
	logic [1:0]   res_n_q;
	logic         rd_q;
	logic         wslot_q;
	logic         wfn_q;

	// decode
	mode_t        d_mode;
	logic [7:0]   d_prev;
	logic [31:0]  d_acc;
	logic         d_neg;
	logic [LW-1:0] d_wlen;
	logic         d_wb_we;
	logic [WIW-1:0] d_wb_idx;
	logic         d_word;
	logic         d_slot;
	logic         d_fn;
	logic [1:0]   d_n;
	logic [3:0]   d_kind [2];
	logic [31:0]  d_val [2];
	logic [7:0]   pchk;

	always_comb begin
		d_mode   = mode_q;
		d_prev   = prev_q;
		d_acc    = acc_q;
		d_neg    = neg_q;
		d_wlen   = wlen_q;
		d_wb_we  = 1'b0;
		d_wb_idx = '0;
		d_word   = 1'b0;
		d_slot   = 1'b0;
		d_fn     = 1'b0;
		d_n      = 2'd0;
		d_kind   = '{default: KIND_OP};
		d_val    = '{default: 32'd0};
		pchk     = prev_q;
		if (!is_dropped(c_q)) begin
			if (mode_q == MODE_WORD && is_letter(c_q)) begin
				if (wlen_q < LW'(MAX_NAME)) begin
					d_wb_we  = 1'b1;
					d_wb_idx = wlen_q[WIW-1:0];
				end
				if (wlen_q <= LW'(MAX_NAME)) begin
					d_wlen = wlen_q + LW'(1);
				end
			end else if (mode_q == MODE_NUM && is_digit(c_q)) begin
				d_acc = add_digit(acc_q, c_q);
			end else if (mode_q == MODE_MINUS && is_digit(c_q)) begin
				d_mode = MODE_NUM;
				d_neg  = 1'b1;
				d_acc  = add_digit(32'd0, c_q);
			end else begin
				unique case (mode_q)
					MODE_WORD: begin
						d_word = 1'b1;
						d_slot = d_n[0];
						d_fn   = (c_q == CH_LPAREN);
						d_n    = d_n + 2'd1;
					end
					MODE_NUM: begin
						d_kind[d_n[0]] = KIND_NUM;
						d_val[d_n[0]]  = fin_num(acc_q, neg_q);
						d_n            = d_n + 2'd1;
					end
					MODE_MINUS: begin
						d_kind[d_n[0]] = KIND_OP;
						d_val[d_n[0]]  = 32'(CH_MINUS);
						d_n            = d_n + 2'd1;
						pchk           = CH_MINUS;
					end
					default: ;
				endcase
				if (is_letter(c_q)) begin
					d_mode   = MODE_WORD;
					d_wb_we  = 1'b1;
					d_wb_idx = '0;
					d_wlen   = LW'(1);
				end else if (is_digit(c_q)) begin
					d_mode = MODE_NUM;
					d_neg  = 1'b0;
					d_acc  = add_digit(32'd0, c_q);
				end else if (c_q == CH_MINUS && !is_letter(pchk) && !is_digit(pchk)) begin
					d_mode = MODE_MINUS;
				end else begin
					d_mode         = MODE_IDLE;
					d_kind[d_n[0]] = KIND_OP;
					d_val[d_n[0]]  = 32'(c_q);
					d_n            = d_n + 2'd1;
				end
			end
			d_prev = c_q;
		end
		if (end_q) begin
			unique case (d_mode)
				MODE_WORD: begin
					d_word = 1'b1;
					d_slot = d_n[0];
					d_fn   = 1'b0;
					d_n    = d_n + 2'd1;
				end
				MODE_NUM: begin
					d_kind[d_n[0]] = KIND_NUM;
					d_val[d_n[0]]  = fin_num(d_acc, d_neg);
					d_n            = d_n + 2'd1;
				end
				MODE_MINUS: begin
					d_kind[d_n[0]] = KIND_OP;
					d_val[d_n[0]]  = 32'(CH_MINUS);
					d_n            = d_n + 2'd1;
				end
				default: ;
			endcase
			d_mode = MODE_IDLE;
			d_prev = 8'd0;
		end
	end

	// word finish
	logic [MAX_NAME*8-1:0] wmask;
	logic                  w_long;
	logic                  kw_hit;
	logic [3:0]            kw_kind;
	logic                  kw_eq;

	always_comb begin
		for (int i = 0; i < MAX_NAME; i++) begin
			wmask[i*8 +: 8] = (LW'(i) < wlen_q) ? wbuf_q[i] : 8'd0;
		end
	end

	always_comb begin
		kw_hit  = 1'b0;
		kw_kind = 4'd0;
		kw_eq   = 1'b0;
		for (int k = KwCount - 1; k >= 0; k--) begin
			kw_eq = (wlen_q == LW'(KW_LEN[k]));
			for (int i = 0; i < KwMaxLen; i++) begin
				if (i < KW_LEN[k] && wbuf_q[i] != kw_char(k, i)) begin
					kw_eq = 1'b0;
				end
			end
			if (kw_eq) begin
				kw_hit  = 1'b1;
				kw_kind = 4'(k);
			end
		end
	end

	assign w_long = wlen_q > LW'(MAX_NAME);

	lws_req_t      st_req;
	lws_resp_t     st_rsp;
	logic [IW-1:0] st_index;

	assign st_req.start = (st_q == T_WORD) && !w_long && !kw_hit;
	assign st_req.fn    = wfn_q;

	lws_symtab #(
		.MAX_NAME    (MAX_NAME),
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_symtab (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (st_req),
		.len    (wlen_q),
		.chars  (wmask),
		.rsp    (st_rsp),
		.index  (st_index)
	);

	logic [3:0] name_kind;
	assign name_kind = wfn_q ? KIND_FUNC : KIND_VAR;

	always_ff @(posedge clk) begin
		if (st_q == T_IDLE && in_valid) begin
			c_q   <= text_char;
			end_q <= end_of_text;
		end
		if (st_q == T_DECODE) begin
			if (d_wb_we) begin
				wbuf_q[d_wb_idx] <= c_q;
			end
			res_kind_q <= d_kind;
			res_val_q  <= d_val;
			res_err_q  <= '{default: ERR_NONE};
			wslot_q    <= d_slot;
			wfn_q      <= d_fn;
		end
		if (st_q == T_WORD) begin
			if (w_long) begin
				res_kind_q[wslot_q] <= name_kind;
				res_val_q[wslot_q]  <= 32'd0;
				res_err_q[wslot_q]  <= ERR_LONG;
			end else if (kw_hit) begin
				res_kind_q[wslot_q] <= kw_kind;
				res_val_q[wslot_q]  <= 32'd0;
				res_err_q[wslot_q]  <= ERR_NONE;
			end
		end
		if (st_q == T_SEARCH && st_rsp.done) begin
			res_kind_q[wslot_q] <= name_kind;
			res_val_q[wslot_q]  <= st_rsp.full ? 32'd0 : 32'(st_index);
			res_err_q[wslot_q]  <= st_rsp.full ? ERR_FULL : ERR_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= T_IDLE;
			mode_q  <= MODE_IDLE;
			wlen_q  <= '0;
			neg_q   <= 1'b0;
			prev_q  <= 8'd0;
			acc_q   <= 32'd0;
			res_n_q <= 2'd0;
			rd_q    <= 1'b0;
		end else begin
			unique case (st_q)
				T_IDLE: begin
					if (in_valid) begin
						st_q <= T_DECODE;
					end
				end
				T_DECODE: begin
					mode_q  <= d_mode;
					prev_q  <= d_prev;
					acc_q   <= d_acc;
					neg_q   <= d_neg;
					wlen_q  <= d_wlen;
					res_n_q <= d_n;
					rd_q    <= 1'b0;
					if (d_word) begin
						st_q <= T_WORD;
					end else if (d_n != 2'd0) begin
						st_q <= T_DRAIN;
					end else begin
						st_q <= T_IDLE;
					end
				end
				T_WORD: begin
					st_q <= (w_long || kw_hit) ? T_DRAIN : T_SEARCH;
				end
				T_SEARCH: begin
					if (st_rsp.done) begin
						st_q <= T_DRAIN;
					end
				end
				T_DRAIN: begin
					if (!out_stall) begin
						if (last_of_run) begin
							st_q    <= T_IDLE;
							res_n_q <= 2'd0;
						end else begin
							rd_q <= 1'b1;
						end
					end
				end
				default: st_q <= T_IDLE;
			endcase
		end
	end

	assign in_stall    = (st_q != T_IDLE);
	assign out_valid   = (st_q == T_DRAIN);
	assign token_kind  = res_kind_q[rd_q];
	assign token_value = res_val_q[rd_q];
	assign error_code  = res_err_q[rd_q];
	assign last_of_run = (2'(rd_q) + 2'd1) == res_n_q;

	a_out_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (res_n_q != 2'd0))
		else $error("result shown with empty result buffer");

	a_no_accept_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while results pending");

	a_done_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		st_rsp.done |-> (st_q == T_SEARCH))
		else $error("table response outside search");

	a_err_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && error_code != ERR_NONE) |-> (token_value == 32'sd0))
		else $error("error token with nonzero value");

endmodule
`default_nettype wire

// ----- sim/lexer_with_symbol_table_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lexer_with_symbol_table_tb
// Feeds character streams (keywords, names, numbers, operators, noise) into
// the lexer and checks every token against a behavioral scanner model or a directed row.
// ----------------------------------------------------------------------------
module lexer_with_symbol_table_tb;
	import lws_pkg::*;

	localparam int MAX_NAME    = MaxNameDef;
	localparam int TABLE_DEPTH = TableDepthDef;
	localparam int WATCHDOG    = 20000;

	typedef enum logic [1:0] {SC_IDLE, SC_WORD, SC_NUM, SC_MINUS} scan_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [31:0] value;
		logic [1:0]  err;
		logic        last;
	} token_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       eot;
		logic       chk;
		token_t     tok;
	} row_t;

	logic        clk, arst_n;
	logic        in_valid, in_stall, end_of_text;
	logic [7:0]  text_char;
	logic        out_valid, out_stall;
	logic [3:0]  token_kind;
	logic signed [31:0] token_value;
	logic [1:0]  error_code;
	logic        last_of_run;

	lexer_with_symbol_table u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.text_char(text_char), .end_of_text(end_of_text),
		.out_valid(out_valid), .out_stall(out_stall),
		.token_kind(token_kind), .token_value(token_value),
		.error_code(error_code), .last_of_run(last_of_run)
	);

	// scanner model state
	scan_t       sc_mode;
	logic [7:0]  wbuf [MAX_NAME];
	int          wlen;
	logic        neg;
	logic [7:0]  prev_ch;
	logic [31:0] acc;
	logic [7:0]  sym_chars [TABLE_DEPTH][MAX_NAME];
	int          sym_len [TABLE_DEPTH];
	logic        sym_fn [TABLE_DEPTH];
	int          sym_count;

	token_t      pending_tokens[$];
	token_t      step_toks[$];
	int          errors;
	int          idle_cycles;
	int          sent;
	bit          hold_rx, quiet;
	row_t        dir_rows[$];
	token_t      dir_expect[$];

	function automatic bit is_letter(logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction
	function automatic bit is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction
	function automatic bit is_blank(logic [7:0] c);
		return c == 0 || c == 32 || (c >= 9 && c <= 13);
	endfunction

	task automatic push_tok(logic [3:0] k, logic [31:0] v, logic [1:0] e);
		token_t t;
		t = '{kind: k, value: v, err: e, last: 1'b0};
		step_toks.push_back(t);
	endtask

	task automatic close_word(logic [7:0] nxt);
		bit fn, hit;
		int k, i, idx;
		fn = (nxt == CH_LPAREN);
		if (wlen > MAX_NAME) begin
			push_tok(fn ? KIND_FUNC : KIND_VAR, 0, ERR_LONG);
			return;
		end
		for (k = 0; k < KwCount; k++) begin
			hit = (KW_LEN[k] == wlen);
			for (i = 0; hit && i < wlen; i++) begin
				logic [KwMaxLen*8-1:0] t;
				t = KW_TEXT[k] << (8 * (KwMaxLen - KW_LEN[k]));
				if (t[8*(KwMaxLen-1-i) +: 8] != wbuf[i]) hit = 0;
			end
			if (hit) begin
				push_tok(k[3:0], 0, ERR_NONE);
				return;
			end
		end
		idx = -1;
		for (k = 0; k < sym_count && idx < 0; k++) begin
			hit = (sym_fn[k] == fn) && (sym_len[k] == wlen);
			for (i = 0; hit && i < wlen; i++)
				if (sym_chars[k][i] != wbuf[i]) hit = 0;
			if (hit) idx = k;
		end
		if (idx < 0) begin
			if (sym_count >= TABLE_DEPTH) begin
				push_tok(fn ? KIND_FUNC : KIND_VAR, 0, ERR_FULL);
				return;
			end
			idx = sym_count;
			for (i = 0; i < wlen; i++) sym_chars[idx][i] = wbuf[i];
			sym_len[idx] = wlen;
			sym_fn[idx] = fn;
			sym_count++;
		end
		push_tok(fn ? KIND_FUNC : KIND_VAR, idx, ERR_NONE);
	endtask

	task automatic close_number();
		logic [31:0] v;
		if (neg) v = 32'd0 - acc;
		else v = (acc > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : acc;
		push_tok(KIND_NUM, v, ERR_NONE);
	endtask

	task automatic add_digit(logic [7:0] c);
		logic [63:0] v;
		v = 64'(acc) * 10 + 64'(c - "0");
		acc = (v > 64'h8000_0000) ? 32'h8000_0000 : v[31:0];
	endtask

	task automatic begin_char(logic [7:0] c);
		if (is_letter(c)) begin
			sc_mode = SC_WORD;
			wlen = 1;
			wbuf[0] = c;
		end else if (is_digit(c)) begin
			sc_mode = SC_NUM;
			neg = 0;
			acc = 0;
			add_digit(c);
		end else if (c == CH_MINUS && !is_letter(prev_ch) && !is_digit(prev_ch)) begin
			sc_mode = SC_MINUS;
		end else begin
			sc_mode = SC_IDLE;
			push_tok(KIND_OP, {24'd0, c}, ERR_NONE);
		end
	endtask

	// predicts tokens for one character and queues them
	task automatic scan_char(logic [7:0] c, logic eot);
		step_toks.delete();
		if (!is_blank(c)) begin
			case (sc_mode)
				SC_WORD: begin
					if (is_letter(c)) begin
						if (wlen < MAX_NAME) wbuf[wlen] = c;
						if (wlen <= MAX_NAME) wlen++;
					end else begin
						close_word(c);
						begin_char(c);
					end
				end
				SC_NUM: begin
					if (is_digit(c)) add_digit(c);
					else begin
						close_number();
						begin_char(c);
					end
				end
				SC_MINUS: begin
					if (is_digit(c)) begin
						sc_mode = SC_NUM;
						neg = 1;
						acc = 0;
						add_digit(c);
					end else begin
						push_tok(KIND_OP, {24'd0, CH_MINUS}, ERR_NONE);
						prev_ch = CH_MINUS;
						begin_char(c);
					end
				end
				default: begin_char(c);
			endcase
			prev_ch = c;
		end
		if (eot) begin
			if (sc_mode == SC_WORD) close_word(8'd0);
			else if (sc_mode == SC_NUM) close_number();
			else if (sc_mode == SC_MINUS) push_tok(KIND_OP, {24'd0, CH_MINUS}, ERR_NONE);
			sc_mode = SC_IDLE;
			prev_ch = 0;
		end
		if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
		foreach (step_toks[i]) pending_tokens.push_back(step_toks[i]);
	endtask

	task automatic report_mismatch(string what, token_t got, token_t exp);
		$display("mismatch %s: got k=%0d v=%0d e=%0d l=%0d exp k=%0d v=%0d e=%0d l=%0d",
			what, got.kind, $signed(got.value), got.err, got.last,
			exp.kind, $signed(exp.value), exp.err, exp.last);
		errors++;
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
	end

	// output side
	initial begin
		token_t got, exp;
		out_stall = 1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			out_stall <= hold_rx || (!quiet && $urandom_range(99) < 24);
			@(posedge clk);
			if (out_valid && !out_stall) begin
				got = '{kind: token_kind, value: token_value, err: error_code,
					last: last_of_run};
				if (pending_tokens.size() == 0) begin
					report_mismatch("unexpected", got, got);
				end else begin
					exp = pending_tokens.pop_front();
					if (dir_expect.size() > 0) begin
						if (got != dir_expect[0]) report_mismatch("directed", got, dir_expect[0]);
						void'(dir_expect.pop_front());
					end else if (got != exp) begin
						report_mismatch("token", got, exp);
					end
				end
			end
		end
	end

	// watchdog
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	task automatic send_char(logic [7:0] c, logic eot);
		while (!quiet && $urandom_range(99) < 24) begin
			in_valid = 0;
			@(negedge clk);
		end
		in_valid = 1;
		text_char = c;
		end_of_text = eot;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		scan_char(c, eot);
		sent++;
		@(negedge clk);
		in_valid = 0;
	endtask

	task automatic send_string(string s, logic eot_at_end);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], eot_at_end && i == s.len() - 1);
	endtask

	function automatic logic [7:0] rand_letter();
		return $urandom_range(1) ? 8'($urandom_range("a", "z")) : 8'($urandom_range("A", "Z"));
	endfunction

	function automatic string rand_word(int maxlen);
		string s;
		int n;
		n = ($urandom_range(19) == 0) ? $urandom_range(MAX_NAME + 1, MAX_NAME + 4)
			: $urandom_range(1, maxlen);
		s = "";
		for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range("a", "a" + 3)))};
		return s;
	endfunction

	initial begin
		token_t z;
		int r, n;
		string s;
		in_valid = 0;
		text_char = 0;
		end_of_text = 0;
		hold_rx = 0;
		quiet = 0;
		errors = 0;
		sent = 0;
		sc_mode = SC_IDLE;
		wlen = 0;
		neg = 0;
		prev_ch = 0;
		acc = 0;
		sym_count = 0;
		z = '0;
		// ch, eot, check typed token, token
		dir_rows = '{
			'{8'd0,   1'b0, 1'b0, z},
			'{"+",    1'b0, 1'b1, '{KIND_OP, 32'd43, ERR_NONE, 1'b1}},
			'{8'd255, 1'b0, 1'b1, '{KIND_OP, 32'd255, ERR_NONE, 1'b1}},
			'{8'd128, 1'b0, 1'b1, '{KIND_OP, 32'd128, ERR_NONE, 1'b1}},
			'{"-",    1'b0, 1'b0, z},
			'{"-",    1'b0, 1'b1, '{KIND_OP, 32'd45, ERR_NONE, 1'b1}},
			'{"Z",    1'b0, 1'b0, z},
			'{"(",    1'b0, 1'b0, z},
			'{"x",    1'b0, 1'b0, z},
			'{8'd9,   1'b0, 1'b0, z},
			'{"y",    1'b1, 1'b0, z},
			'{"9",    1'b0, 1'b0, z},
			'{"-",    1'b0, 1'b0, z},
			'{"1",    1'b1, 1'b0, z},
			'{"-",    1'b1, 1'b1, '{KIND_OP, 32'd45, ERR_NONE, 1'b1}},
			'{"0",    1'b1, 1'b1, '{KIND_NUM, 32'd0, ERR_NONE, 1'b1}},
			'{8'd13,  1'b1, 1'b0, z},
			'{8'd127, 1'b1, 1'b1, '{KIND_OP, 32'd127, ERR_NONE, 1'b1}},
			'{8'd32,  1'b0, 1'b0, z},
			'{"a",    1'b0, 1'b0, z},
			'{"1",    1'b1, 1'b0, z}
		};
		@(posedge arst_n);
		@(negedge clk);
		foreach (dir_rows[i]) begin
			if (dir_rows[i].chk) begin
				wait (pending_tokens.size() == 0);
				dir_expect.push_back(dir_rows[i].tok);
			end
			send_char(dir_rows[i].ch, dir_rows[i].eot);
			if (dir_rows[i].chk) wait (dir_expect.size() == 0);
		end
		// keywords, saturation and an over-long name
		send_string("itakenooffence iamoffended oneminute leavemealone givememoney ", 0);
		send_string("gototheshop", 1);
		send_string("-99999999999+99999999999;2147483648 -2147483648", 1);
		send_string("abcdefghijklmnopqrstu(", 1);
		// random part: well-formed fragments with noise
		quiet = 1;
		for (int i = 0; sent < 650; i++) begin
			if (i == 60) quiet = 0;
			if (i == 80) begin
				fork
					begin
						hold_rx = 1;
						repeat (300) @(posedge clk);
						hold_rx = 0;
					end
				join_none
			end
			// fill the table past its depth partway through
			if (i == 40)
				for (int k = 0; k < TABLE_DEPTH + 4; k++) begin
					send_char(8'("q" + k / 26), 0);
					send_char(8'("a" + k % 26), 0);
					send_char(";", 0);
				end
			r = $urandom_range(99);
			if (r < 35) begin
				s = rand_word(5);
				send_string(s, 0);
				if ($urandom_range(2) == 0) send_char("(", 0);
			end else if (r < 55) begin
				if ($urandom_range(1)) send_char("-", 0);
				n = $urandom_range(1, ($urandom_range(9) == 0) ? 12 : 4);
				for (int k = 0; k < n; k++) send_char(8'($urandom_range("0", "9")), 0);
			end else if (r < 65) begin
				send_char(rand_letter(), 0);
			end else if (r < 75) begin
				send_char(8'($urandom_range(255)), $urandom_range(9) == 0);
			end else if (r < 85) begin
				send_char(8'($urandom_range(1) ? 32 : $urandom_range(9, 13)), 0);
			end else begin
				send_char(8'(" " + $urandom_range(1, 15)), $urandom_range(7) == 0);
			end
		end
		send_char(";", 1);
		wait (pending_tokens.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0 && pending_tokens.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ----- sim.f -----
rtl/lws_pkg.sv
rtl/lws_symtab.sv
rtl/lexer_with_symbol_table.sv
sim/lexer_with_symbol_table_tb.sv
